// ----- rtl/jmss_pkg.sv -----
// Shared types and constants for the JPEG marker segment scanner.
// No dependencies; imported by the scanner top level and its checker.
package jmss_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } jmss_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] byte_value;
    logic [3:0] marker_class;
    logic       short_length;
  } jmss_result_t;

  typedef enum logic [2:0] {
    PH_SCAN    = 3'd0,
    PH_MARKER  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_SKIP    = 3'd4,
    PH_STOPPED = 3'd5
  } jmss_phase_t;

  localparam logic [1:0] EV_DATA   = 2'd0;
  localparam logic [1:0] EV_MARKER = 2'd1;
  localparam logic [1:0] EV_END    = 2'd2;

  localparam logic [3:0] CLASS_SOI     = 4'd0;
  localparam logic [3:0] CLASS_APP0    = 4'd1;
  localparam logic [3:0] CLASS_APP13   = 4'd2;
  localparam logic [3:0] CLASS_COM     = 4'd3;
  localparam logic [3:0] CLASS_APP14   = 4'd4;
  localparam logic [3:0] CLASS_DQT     = 4'd5;
  localparam logic [3:0] CLASS_SOF0    = 4'd6;
  localparam logic [3:0] CLASS_DRI     = 4'd7;
  localparam logic [3:0] CLASS_DHT     = 4'd8;
  localparam logic [3:0] CLASS_SOS     = 4'd9;
  localparam logic [3:0] CLASS_EOI     = 4'd10;
  localparam logic [3:0] CLASS_UNKNOWN = 4'd11;

  localparam logic [7:0] CODE_PREFIX = 8'hff;
  localparam logic [7:0] CODE_SOI    = 8'hd8;
  localparam logic [7:0] CODE_EOI    = 8'hd9;
  localparam logic [7:0] CODE_APP0   = 8'he0;
  localparam logic [7:0] CODE_APP13  = 8'hed;
  localparam logic [7:0] CODE_COM    = 8'hfe;
  localparam logic [7:0] CODE_APP14  = 8'hee;
  localparam logic [7:0] CODE_DQT    = 8'hdb;
  localparam logic [7:0] CODE_SOF0   = 8'hc0;
  localparam logic [7:0] CODE_DRI    = 8'hdd;
  localparam logic [7:0] CODE_DHT    = 8'hc4;
  localparam logic [7:0] CODE_SOS    = 8'hda;

  // Class of a marker code.
  function automatic logic [3:0] marker_class_of(input logic [7:0] code);
    logic [3:0] cls;
    case (code)
      CODE_APP0:  cls = CLASS_APP0;
      CODE_APP13: cls = CLASS_APP13;
      CODE_COM:   cls = CLASS_COM;
      CODE_APP14: cls = CLASS_APP14;
      CODE_DQT:   cls = CLASS_DQT;
      CODE_SOF0:  cls = CLASS_SOF0;
      CODE_DRI:   cls = CLASS_DRI;
      CODE_DHT:   cls = CLASS_DHT;
      CODE_SOI:   cls = CLASS_SOI;
      CODE_SOS:   cls = CLASS_SOS;
      CODE_EOI:   cls = CLASS_EOI;
      default:    cls = CLASS_UNKNOWN;
    endcase
    return cls;
  endfunction

  // True for markers that are followed by a length field.
  function automatic logic marker_has_length(input logic [3:0] cls);
    return (cls >= CLASS_APP0) && (cls <= CLASS_DHT);
  endfunction

endpackage

// ----- rtl/jpeg_marker_segment_scanner.sv -----
// A result is registered and appears in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the only limit is the single result register,
// so a byte is held back only while a waiting result is stalled.
// Reset (rst, synchronous) returns the scan to its start and empties the result
// register. A byte with first_byte set restarts the scan the same way.
// Depends on jmss_pkg.
module jpeg_marker_segment_scanner (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  jmss_pkg::jmss_item_t  item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output jmss_pkg::jmss_result_t result
);
  import jmss_pkg::*;

  jmss_phase_t  phase, phase_next;
  logic [15:0]  skip_remaining, skip_remaining_next;
  logic [7:0]   length_high, length_high_next;
  logic [7:0]   pending_code, pending_code_next;
  logic         emit;
  jmss_result_t emit_data;
  logic         accept;

  jmss_phase_t  cur_phase;
  logic [3:0]   cls;
  logic [3:0]   pending_cls;
  logic [15:0]  seg_len;
  logic         len_short;
  logic [15:0]  len_minus2;

  // The result register is free when empty or being taken this cycle.
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  assign cur_phase   = item.first_byte ? PH_SCAN : phase;
  assign cls         = marker_class_of(item.data_byte);
  assign pending_cls = marker_class_of(pending_code);
  assign seg_len     = {length_high, item.data_byte};
  assign len_short   = (length_high == 8'd0) && (item.data_byte[7:1] == 7'd0);
  assign len_minus2  = seg_len - 16'd2;

  // Next-state logic.
  always_comb begin
    phase_next          = cur_phase;
    skip_remaining_next = item.first_byte ? 16'd0 : skip_remaining;
    length_high_next    = item.first_byte ? 8'd0 : length_high;
    pending_code_next   = item.first_byte ? 8'd0 : pending_code;
    case (cur_phase)
      PH_SCAN: begin
        if (item.data_byte == CODE_PREFIX) phase_next = PH_MARKER;
      end
      PH_MARKER: begin
        if (cls == CLASS_EOI) begin
          phase_next = PH_STOPPED;
        end else if (marker_has_length(cls)) begin
          pending_code_next = item.data_byte;
          phase_next        = PH_LEN_HI;
        end else begin
          phase_next = PH_SCAN;
        end
      end
      PH_LEN_HI: begin
        length_high_next = item.data_byte;
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (len_short || len_minus2 == 16'd0) begin
          skip_remaining_next = 16'd0;
          phase_next          = PH_SCAN;
        end else begin
          skip_remaining_next = len_minus2;
          phase_next          = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_remaining_next = skip_remaining - 16'd1;
        if (skip_remaining == 16'd1) phase_next = PH_SCAN;
      end
      default: phase_next = PH_STOPPED;
    endcase
  end

  // Result selection.
  always_comb begin
    emit      = 1'b0;
    emit_data = '{event_kind: EV_DATA, byte_value: item.data_byte,
                  marker_class: CLASS_SOI, short_length: 1'b0};
    case (cur_phase)
      PH_SCAN: begin
        emit = (item.data_byte != CODE_PREFIX);
      end
      PH_MARKER: begin
        if (cls == CLASS_EOI) begin
          emit                   = 1'b1;
          emit_data.event_kind   = EV_END;
          emit_data.marker_class = cls;
        end else if (!marker_has_length(cls)) begin
          emit                   = 1'b1;
          emit_data.event_kind   = EV_MARKER;
          emit_data.marker_class = cls;
        end
      end
      PH_LEN_LO: begin
        // Length-bearing markers are reported once the length is known.
        emit                   = 1'b1;
        emit_data.event_kind   = EV_MARKER;
        emit_data.byte_value   = pending_code;
        emit_data.marker_class = pending_cls;
        emit_data.short_length = len_short;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SCAN;
      skip_remaining <= 16'd0;
      length_high    <= 8'd0;
      pending_code   <= 8'd0;
      result_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        skip_remaining <= skip_remaining_next;
        length_high    <= length_high_next;
        pending_code   <= pending_code_next;
        result_valid   <= emit;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) result <= emit_data;
  end

endmodule

// ----- rtl/jmss_checker.sv -----
// Port-level checks for the JPEG marker segment scanner, bound to the top level.
// Depends on jmss_pkg and jpeg_marker_segment_scanner.
module jmss_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   item_valid,
  input logic                   item_stall,
  input jmss_pkg::jmss_item_t   item,
  input logic                   result_valid,
  input logic                   result_stall,
  input jmss_pkg::jmss_result_t result
);
  import jmss_pkg::*;

  // A stalled result stays in place.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Input is held back only by a stalled waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled without a waiting result");

  // A restart byte that is not a prefix comes straight out as a data byte.
  a_restart_data: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.first_byte && item.data_byte != CODE_PREFIX
    |=> result_valid && result.event_kind == EV_DATA &&
        result.byte_value == $past(item.data_byte))
    else $error("restart data byte not reported");

  // Data results carry the default class CLASS_SOI and no short-length flag.
  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.event_kind == EV_DATA
    |-> result.marker_class == CLASS_SOI && !result.short_length)
    else $error("data result carries marker fields");

  // The short-length flag appears only on length-bearing marker reports.
  a_short_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.short_length
    |-> result.event_kind == EV_MARKER && marker_has_length(result.marker_class))
    else $error("short length on a marker without a length");

endmodule

bind jpeg_marker_segment_scanner jmss_checker u_jmss_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
